### rtl/eilpc_pkg.sv
// ----------------------------------------------------------------------------
// eilpc_pkg
// Shared types and constants for the Ethernet/IPv4 L4 port classifier.
// ----------------------------------------------------------------------------
package eilpc_pkg;

	typedef enum logic [1:0] {
		CAT_OTHER_ETH   = 2'd0,
		CAT_OTHER_PROTO = 2'd1,
		CAT_UDP         = 2'd2,
		CAT_TCP         = 2'd3
	} category_t;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [7:0]  TCP_SYN_ONLY   = 8'h02;
	localparam logic [3:0]  IP_VERSION_4   = 4'd4;

	localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
	localparam logic [15:0] IPV4_MIN_LEN   = 16'd20;
	localparam logic [15:0] TCP_MIN_LEN    = 16'd20;
	localparam logic [15:0] UDP_MIN_LEN    = 16'd8;

	localparam logic [6:0]  POS_ETYPE_HI   = 7'd12;
	localparam logic [6:0]  POS_ETYPE_LO   = 7'd13;
	localparam logic [6:0]  POS_VER_IHL    = 7'd14;
	localparam logic [6:0]  POS_TLEN_HI    = 7'd16;
	localparam logic [6:0]  POS_TLEN_LO    = 7'd17;
	localparam logic [6:0]  POS_PROTO      = 7'd23;

	localparam logic [6:0]  OFS_DPORT_HI   = 7'd2;
	localparam logic [6:0]  OFS_DPORT_LO   = 7'd3;
	localparam logic [6:0]  OFS_ULEN_HI    = 7'd4;
	localparam logic [6:0]  OFS_ULEN_LO    = 7'd5;
	localparam logic [6:0]  OFS_TCP_OFF    = 7'd12;
	localparam logic [6:0]  OFS_TCP_FLAGS  = 7'd13;

endpackage

### rtl/eth_ipv4_l4_port_classifier.sv
// ----------------------------------------------------------------------------
// eth_ipv4_l4_port_classifier
// Parses an Ethernet frame one byte per beat and emits one classification
// (ethertype, IP protocol, UDP or TCP with destination port) per valid frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | sink      | in_valid, in_stall  | frame_byte[7:0], last_byte
//  out     | source    | out_valid, out_stall| category[1:0], new_connection, key[15:0]
//
//  One byte per cycle while in_stall is low; a last byte passes through the input
//  register and then the result register; fields are captured into per-frame
//  registers as each byte leaves the input register.
//  Reset clears all control and frame state; no clearing pass is needed.
//  in_stall rises only when a last byte waits behind a stalled result.
// ----------------------------------------------------------------------------
module eth_ipv4_l4_port_classifier #(
	parameter int LEN_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  category,
	output logic        new_connection,
	output logic [15:0] key
);

	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

	logic                s1_vld_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                s1_take;
	logic                in_acc;

	logic [LEN_BITS-1:0] byte_count_q;
	logic [15:0]         ether_type_q;
	logic [7:0]          version_ihl_q;
	logic [15:0]         ip_total_length_q;
	logic [7:0]          ip_protocol_q;
	logic [15:0]         dest_port_q;
	logic [3:0]          tcp_offset_words_q;
	logic [7:0]          tcp_flag_bits_q;
	logic [15:0]         udp_length_q;

	logic [15:0]         ether_type_nx;
	logic [7:0]          version_ihl_nx;
	logic [15:0]         ip_total_length_nx;
	logic [7:0]          ip_protocol_nx;
	logic [15:0]         dest_port_nx;
	logic [3:0]          tcp_offset_words_nx;
	logic [7:0]          tcp_flag_bits_nx;
	logic [15:0]         udp_length_nx;
	logic [LEN_BITS-1:0] len;
	logic [6:0]          t_ofs;
	logic                pos_small;
	logic [6:0]          pos7;

	logic [15:0]         len16;
	logic [15:0]         p_len;
	logic [15:0]         hl;
	logic [15:0]         r_len;
	logic                emit;
	eilpc_pkg::category_t cat_nx;
	logic                newc_nx;
	logic [15:0]         key_nx;

	logic                out_vld_q;
	eilpc_pkg::category_t cat_q;
	logic                newc_q;
	logic [15:0]         key_q;

	assign s1_take  = s1_vld_s1 & (~out_vld_q | ~out_stall | ~last_s1);
	assign in_stall = s1_vld_s1 & ~s1_take;
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
		end else if (in_acc) begin
			s1_vld_s1 <= 1'b1;
		end else if (s1_take) begin
			s1_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= frame_byte;
			last_s1 <= last_byte;
		end
	end

	// field capture
	always_comb begin
		pos_small = (byte_count_q < LEN_BITS'(128));
		pos7      = byte_count_q[6:0];
		t_ofs     = eilpc_pkg::POS_VER_IHL + {1'b0, version_ihl_q[3:0], 2'b00};

		ether_type_nx       = ether_type_q;
		version_ihl_nx      = version_ihl_q;
		ip_total_length_nx  = ip_total_length_q;
		ip_protocol_nx      = ip_protocol_q;
		dest_port_nx        = dest_port_q;
		tcp_offset_words_nx = tcp_offset_words_q;
		tcp_flag_bits_nx    = tcp_flag_bits_q;
		udp_length_nx       = udp_length_q;

		if (pos_small) begin
			if (pos7 == eilpc_pkg::POS_ETYPE_HI) ether_type_nx[15:8] = byte_s1;
			if (pos7 == eilpc_pkg::POS_ETYPE_LO) ether_type_nx[7:0] = byte_s1;
			if (pos7 == eilpc_pkg::POS_VER_IHL) version_ihl_nx = byte_s1;
			if (pos7 == eilpc_pkg::POS_TLEN_HI) ip_total_length_nx[15:8] = byte_s1;
			if (pos7 == eilpc_pkg::POS_TLEN_LO) ip_total_length_nx[7:0] = byte_s1;
			if (pos7 == eilpc_pkg::POS_PROTO) ip_protocol_nx = byte_s1;
			if (pos7 > eilpc_pkg::POS_VER_IHL) begin
				if (pos7 == t_ofs + eilpc_pkg::OFS_DPORT_HI) dest_port_nx[15:8] = byte_s1;
				if (pos7 == t_ofs + eilpc_pkg::OFS_DPORT_LO) dest_port_nx[7:0] = byte_s1;
				if (pos7 == t_ofs + eilpc_pkg::OFS_ULEN_HI) udp_length_nx[15:8] = byte_s1;
				if (pos7 == t_ofs + eilpc_pkg::OFS_ULEN_LO) udp_length_nx[7:0] = byte_s1;
				if (pos7 == t_ofs + eilpc_pkg::OFS_TCP_OFF) tcp_offset_words_nx = byte_s1[7:4];
				if (pos7 == t_ofs + eilpc_pkg::OFS_TCP_FLAGS) tcp_flag_bits_nx = byte_s1;
			end
		end

		len = (byte_count_q != LEN_MAX) ? byte_count_q + LEN_BITS'(1) : LEN_MAX;
	end

	// classification on the last beat
	always_comb begin
		len16   = 16'(len);
		p_len   = len16 - eilpc_pkg::ETH_HDR_LEN;
		hl      = {10'd0, version_ihl_nx[3:0], 2'b00};
		r_len   = p_len - hl;
		emit    = 1'b0;
		cat_nx  = eilpc_pkg::CAT_OTHER_ETH;
		newc_nx = 1'b0;
		key_nx  = ether_type_nx;

		priority if (len16 < eilpc_pkg::ETH_HDR_LEN) begin
			emit = 1'b0;
		end else if (ether_type_nx != eilpc_pkg::ETHERTYPE_IPV4) begin
			emit = 1'b1;
		end else if (p_len < eilpc_pkg::IPV4_MIN_LEN
				|| version_ihl_nx[7:4] != eilpc_pkg::IP_VERSION_4
				|| p_len < hl || p_len < ip_total_length_nx) begin
			emit = 1'b0;
		end else if (ip_protocol_nx == eilpc_pkg::PROTO_TCP) begin
			emit    = (r_len >= eilpc_pkg::TCP_MIN_LEN)
				&& (r_len >= {10'd0, tcp_offset_words_nx, 2'b00});
			cat_nx  = eilpc_pkg::CAT_TCP;
			newc_nx = (tcp_flag_bits_nx == eilpc_pkg::TCP_SYN_ONLY);
			key_nx  = dest_port_nx;
		end else if (ip_protocol_nx == eilpc_pkg::PROTO_UDP) begin
			emit   = (r_len >= eilpc_pkg::UDP_MIN_LEN) && (r_len >= udp_length_nx);
			cat_nx = eilpc_pkg::CAT_UDP;
			key_nx = dest_port_nx;
		end else begin
			emit   = 1'b1;
			cat_nx = eilpc_pkg::CAT_OTHER_PROTO;
			key_nx = {8'd0, ip_protocol_nx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q       <= '0;
			ether_type_q       <= '0;
			version_ihl_q      <= '0;
			ip_total_length_q  <= '0;
			ip_protocol_q      <= '0;
			dest_port_q        <= '0;
			tcp_offset_words_q <= '0;
			tcp_flag_bits_q    <= '0;
			udp_length_q       <= '0;
		end else if (s1_take) begin
			if (last_s1) begin
				byte_count_q       <= '0;
				ether_type_q       <= '0;
				version_ihl_q      <= '0;
				ip_total_length_q  <= '0;
				ip_protocol_q      <= '0;
				dest_port_q        <= '0;
				tcp_offset_words_q <= '0;
				tcp_flag_bits_q    <= '0;
				udp_length_q       <= '0;
			end else begin
				byte_count_q       <= len;
				ether_type_q       <= ether_type_nx;
				version_ihl_q      <= version_ihl_nx;
				ip_total_length_q  <= ip_total_length_nx;
				ip_protocol_q      <= ip_protocol_nx;
				dest_port_q        <= dest_port_nx;
				tcp_offset_words_q <= tcp_offset_words_nx;
				tcp_flag_bits_q    <= tcp_flag_bits_nx;
				udp_length_q       <= udp_length_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_take && last_s1 && emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && last_s1 && emit) begin
			cat_q  <= cat_nx;
			newc_q <= newc_nx;
			key_q  <= key_nx;
		end
	end

	assign out_valid      = out_vld_q;
	assign category       = cat_q;
	assign new_connection = newc_q;
	assign key            = key_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_vld_s1 && last_s1 && out_vld_q))
		else $error("input stalled without a blocked last beat");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_take && last_s1) |=> (byte_count_q == '0 && ether_type_q == 16'd0))
		else $error("frame state not cleared after last beat");

	a_syn_only_tcp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && new_connection) |-> (category == eilpc_pkg::CAT_TCP))
		else $error("new connection flagged outside TCP");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(s1_vld_s1 && last_s1))
		else $error("result without a last beat");

endmodule

### sim/eth_ipv4_l4_port_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_ipv4_l4_port_classifier_tb
// Sends Ethernet frames one byte per beat and checks each classification
// against a cycle-free frame parser kept in the bench. Covers short and
// malformed frames, every category, the SYN flag, small and large IHL,
// random traffic with gaps on both sides, and a long result hold-off that
// backs up the input.
// ----------------------------------------------------------------------------
module eth_ipv4_l4_port_classifier_tb;

	localparam int          LEN_BITS      = 16;
	localparam int unsigned LEN_MAX       = (1 << LEN_BITS) - 1;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          STALL_LIMIT   = 4000;
	localparam int          SETTLE_CYCLES = 8;

	typedef struct packed {
		eilpc_pkg::category_t cat;
		logic                 conn;
		logic [15:0]          key;
	} verdict_t;

	typedef struct {
		bit          raw;
		int unsigned len;
		bit [15:0]   etype;
		bit [7:0]    vihl;
		bit [15:0]   tlen;
		bit [7:0]    proto;
		bit [15:0]   dport;
		bit [15:0]   ulen;
		bit [3:0]    toff;
		bit [7:0]    flags;
	} hdr_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  frame_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  category;
	logic        new_connection;
	logic [15:0] key;

	bit [15:0] pos_q, etype_q, tlen_q, dport_q, ulen_q;
	bit [7:0]  vihl_q, proto_q, flags_q;
	bit [3:0]  toff_q;

	verdict_t    verdict_q[$];
	bit [7:0]    frame_buf[$];
	bit          tx_idle_on, rx_idle_on, hold_req;
	int unsigned fail_count, beats_sent, frames_sent, verdicts_predicted;
	int unsigned results_checked, syn_seen, in_held;
	int unsigned cat_seen[4];

	eth_ipv4_l4_port_classifier #(.LEN_BITS(LEN_BITS)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.frame_byte     (frame_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.category       (category),
		.new_connection (new_connection),
		.key            (key)
	);

	always #2 clk = ~clk;

	function automatic void clear_frame_state();
		pos_q = '0; etype_q = '0; vihl_q = '0; tlen_q = '0; proto_q = '0;
		dport_q = '0; toff_q = '0; flags_q = '0; ulen_q = '0;
	endfunction

	function automatic void classify_byte(input bit [7:0] b, input bit is_last);
		int unsigned pos, t, len, p, hl, r;
		verdict_t    v;
		bit          hit;
		pos = 32'(pos_q);
		t   = eilpc_pkg::ETH_HDR_LEN + vihl_q[3:0] * 4;
		if (pos == eilpc_pkg::POS_ETYPE_HI) etype_q[15:8] = b;
		if (pos == eilpc_pkg::POS_ETYPE_LO) etype_q[7:0] = b;
		if (pos == eilpc_pkg::POS_VER_IHL) vihl_q = b;
		if (pos == eilpc_pkg::POS_TLEN_HI) tlen_q[15:8] = b;
		if (pos == eilpc_pkg::POS_TLEN_LO) tlen_q[7:0] = b;
		if (pos == eilpc_pkg::POS_PROTO) proto_q = b;
		if (pos > eilpc_pkg::POS_VER_IHL) begin
			if (pos == t + eilpc_pkg::OFS_DPORT_HI) dport_q[15:8] = b;
			if (pos == t + eilpc_pkg::OFS_DPORT_LO) dport_q[7:0] = b;
			if (pos == t + eilpc_pkg::OFS_ULEN_HI) ulen_q[15:8] = b;
			if (pos == t + eilpc_pkg::OFS_ULEN_LO) ulen_q[7:0] = b;
			if (pos == t + eilpc_pkg::OFS_TCP_OFF) toff_q = b[7:4];
			if (pos == t + eilpc_pkg::OFS_TCP_FLAGS) flags_q = b;
		end
		len   = (pos < LEN_MAX) ? pos + 1 : LEN_MAX;
		pos_q = len[15:0];
		if (!is_last)
			return;
		hit = 1'b0;
		v   = '0;
		if (len >= eilpc_pkg::ETH_HDR_LEN) begin
			if (etype_q != eilpc_pkg::ETHERTYPE_IPV4) begin
				v   = '{eilpc_pkg::CAT_OTHER_ETH, 1'b0, etype_q};
				hit = 1'b1;
			end else begin
				p  = len - eilpc_pkg::ETH_HDR_LEN;
				hl = vihl_q[3:0] * 4;
				if (p >= eilpc_pkg::IPV4_MIN_LEN &&
				    vihl_q[7:4] == eilpc_pkg::IP_VERSION_4 &&
				    p >= hl && p >= tlen_q) begin
					r = p - hl;
					if (proto_q == eilpc_pkg::PROTO_TCP) begin
						if (r >= eilpc_pkg::TCP_MIN_LEN && r >= toff_q * 4) begin
							v   = '{eilpc_pkg::CAT_TCP,
							        flags_q == eilpc_pkg::TCP_SYN_ONLY, dport_q};
							hit = 1'b1;
						end
					end else if (proto_q == eilpc_pkg::PROTO_UDP) begin
						if (r >= eilpc_pkg::UDP_MIN_LEN && r >= ulen_q) begin
							v   = '{eilpc_pkg::CAT_UDP, 1'b0, dport_q};
							hit = 1'b1;
						end
					end else begin
						v   = '{eilpc_pkg::CAT_OTHER_PROTO, 1'b0, {8'h00, proto_q}};
						hit = 1'b1;
					end
				end
			end
		end
		if (hit) begin
			verdict_q.push_back(v);
			verdicts_predicted++;
		end
		clear_frame_state();
	endfunction

	function automatic void put_byte(input int unsigned i, input bit [7:0] v);
		if (i < frame_buf.size())
			frame_buf[i] = v;
	endfunction

	function automatic void fill_frame(input hdr_t h);
		int unsigned t;
		frame_buf.delete();
		for (int unsigned i = 0; i < h.len; i++)
			frame_buf.push_back(8'($urandom));
		if (h.raw)
			return;
		t = eilpc_pkg::ETH_HDR_LEN + h.vihl[3:0] * 4;
		put_byte(eilpc_pkg::POS_ETYPE_HI, h.etype[15:8]);
		put_byte(eilpc_pkg::POS_ETYPE_LO, h.etype[7:0]);
		put_byte(eilpc_pkg::POS_VER_IHL, h.vihl);
		put_byte(eilpc_pkg::POS_TLEN_HI, h.tlen[15:8]);
		put_byte(eilpc_pkg::POS_TLEN_LO, h.tlen[7:0]);
		put_byte(eilpc_pkg::POS_PROTO, h.proto);
		put_byte(t + eilpc_pkg::OFS_DPORT_HI, h.dport[15:8]);
		put_byte(t + eilpc_pkg::OFS_DPORT_LO, h.dport[7:0]);
		put_byte(t + eilpc_pkg::OFS_ULEN_HI, h.ulen[15:8]);
		put_byte(t + eilpc_pkg::OFS_ULEN_LO, h.ulen[7:0]);
		put_byte(t + eilpc_pkg::OFS_TCP_OFF, {h.toff, 4'($urandom)});
		put_byte(t + eilpc_pkg::OFS_TCP_FLAGS, h.flags);
	endfunction

	function automatic hdr_t base_hdr(input bit [7:0] proto, input bit [3:0] ihl,
	                                  input int unsigned l4len);
		hdr_t h;
		h.raw   = 1'b0;
		h.etype = eilpc_pkg::ETHERTYPE_IPV4;
		h.vihl  = {eilpc_pkg::IP_VERSION_4, ihl};
		h.proto = proto;
		h.tlen  = 16'(ihl * 4 + l4len);
		h.len   = eilpc_pkg::ETH_HDR_LEN + ihl * 4 + l4len;
		h.dport = 16'($urandom);
		h.ulen  = 16'(l4len);
		h.toff  = 4'd5;
		h.flags = 8'($urandom);
		return h;
	endfunction

	function automatic hdr_t wellformed_hdr();
		hdr_t        h;
		int unsigned sel, ihl, toff, l4len;
		bit [7:0]    proto;
		sel = $urandom_range(0, 9);
		ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
		if (sel < 4) begin
			toff  = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 15) : 5;
			l4len = toff * 4 + $urandom_range(0, 16);
			h     = base_hdr(eilpc_pkg::PROTO_TCP, 4'(ihl), l4len);
			h.toff = 4'(toff);
			if ($urandom_range(0, 2) == 0)
				h.flags = eilpc_pkg::TCP_SYN_ONLY;
		end else if (sel < 8) begin
			l4len = 8 + $urandom_range(0, 24);
			h     = base_hdr(eilpc_pkg::PROTO_UDP, 4'(ihl), l4len);
			h.ulen = 16'(8 + $urandom_range(0, l4len - 8));
		end else begin
			proto = 8'($urandom);
			while (proto == eilpc_pkg::PROTO_TCP || proto == eilpc_pkg::PROTO_UDP)
				proto = 8'($urandom);
			h = base_hdr(proto, 4'(ihl), $urandom_range(0, 24));
		end
		if ($urandom_range(0, 2) == 0)
			h.len += $urandom_range(1, 4);
		if (sel == 9) begin
			h.etype = 16'($urandom);
			if (h.etype == eilpc_pkg::ETHERTYPE_IPV4)
				h.etype = ~h.etype;
			h.len = $urandom_range(14, 64);
		end
		return h;
	endfunction

	function automatic hdr_t noisy_hdr();
		hdr_t h;
		h = wellformed_hdr();
		case ($urandom_range(0, 6))
			0: h.len = $urandom_range(1, h.len);
			1: h.vihl = 8'($urandom);
			2: h.tlen = 16'($urandom_range(0, h.tlen + 8));
			3: h.ulen = 16'($urandom);
			4: h.toff = 4'($urandom);
			5: begin
				h.etype = eilpc_pkg::ETHERTYPE_IPV4;
				h.vihl  = {eilpc_pkg::IP_VERSION_4, 4'($urandom_range(0, 4))};
			end
			default: begin
				h.raw = 1'b1;
				h.len = $urandom_range(1, 80);
			end
		endcase
		return h;
	endfunction

	task automatic send_beat(input bit [7:0] b, input bit is_last);
		bit stalled;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		frame_byte <= b;
		last_byte  <= is_last;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		classify_byte(b, is_last);
		beats_sent++;
	endtask

	task automatic send_frame(input hdr_t h);
		fill_frame(h);
		foreach (frame_buf[i])
			send_beat(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	task automatic finish_phase();
		in_valid  <= 1'b0;
		last_byte <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed_cases();
		hdr_t h;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		h = base_hdr(eilpc_pkg::PROTO_TCP, 4'd5, 20);
		h.raw = 1'b1;
		h.len = 1;
		send_frame(h);
		h.len = 13;
		send_frame(h);
		h = base_hdr(eilpc_pkg::PROTO_UDP, 4'd5, 8);
		h.etype = 16'hffff;
		h.len   = 14;
		send_frame(h);
		h.etype = 16'h0000;
		send_frame(h);
		h.etype = 16'h86dd;
		h.len   = 60;
		send_frame(h);
		h = base_hdr(8'd1, 4'd5, 0);
		h.len = 33;
		send_frame(h);
		h.len = 34;
		send_frame(h);
		h.vihl = 8'h65;
		send_frame(h);
		h = base_hdr(eilpc_pkg::PROTO_TCP, 4'd5, 20);
		h.vihl = 8'h4f;
		send_frame(h);
		h = base_hdr(eilpc_pkg::PROTO_TCP, 4'd15, 20);
		send_frame(h);
		h = base_hdr(eilpc_pkg::PROTO_UDP, 4'd5, 8);
		h.tlen = h.tlen + 16'd1;
		send_frame(h);
		h = base_hdr(eilpc_pkg::PROTO_TCP, 4'd0, 40);
		h.dport = 16'd40;
		send_frame(h);
		h = base_hdr(eilpc_pkg::PROTO_TCP, 4'd4, 24);
		send_frame(h);
		send_frame(base_hdr(8'h00, 4'd5, 4));
		send_frame(base_hdr(8'hff, 4'd5, 4));
		h = base_hdr(eilpc_pkg::PROTO_TCP, 4'd5, 20);
		h.flags = eilpc_pkg::TCP_SYN_ONLY;
		h.dport = 16'hffff;
		send_frame(h);
		h.flags = 8'h12;
		h.dport = 16'h0000;
		send_frame(h);
		h.flags = 8'h00;
		send_frame(h);
		send_frame(base_hdr(eilpc_pkg::PROTO_TCP, 4'd5, 19));
		h = base_hdr(eilpc_pkg::PROTO_TCP, 4'd5, 59);
		h.toff = 4'd15;
		send_frame(h);
		h = base_hdr(eilpc_pkg::PROTO_TCP, 4'd5, 60);
		h.toff = 4'd15;
		send_frame(h);
		h = base_hdr(eilpc_pkg::PROTO_TCP, 4'd5, 20);
		h.toff = 4'd0;
		send_frame(h);
		send_frame(base_hdr(eilpc_pkg::PROTO_UDP, 4'd5, 7));
		h = base_hdr(eilpc_pkg::PROTO_UDP, 4'd5, 8);
		h.ulen = 16'd9;
		send_frame(h);
		h.ulen  = 16'd0;
		h.dport = 16'hffff;
		send_frame(h);
		h.ulen = 16'hffff;
		send_frame(h);
		finish_phase();
	endtask

	task automatic test_random_traffic();
		int unsigned beats0, n;
		beats0 = beats_sent;
		n      = 0;
		while (beats_sent - beats0 < 350) begin
			if (n % 8 == 0) begin
				tx_idle_on = $urandom_range(0, 3) != 0;
				rx_idle_on = $urandom_range(0, 3) != 0;
			end
			send_frame(($urandom_range(0, 4) == 0) ? noisy_hdr() : wellformed_hdr());
			n++;
		end
		finish_phase();
	endtask

	task automatic test_back_pressure();
		hdr_t h;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_req   = 1'b1;
		for (int i = 0; i < 9; i++) begin
			h = base_hdr(eilpc_pkg::PROTO_UDP, 4'd5, 8);
			if (i % 3 == 0)
				h.etype = 16'h88cc;
			h.len = (i % 3 == 0) ? 14 : h.len;
			send_frame(h);
		end
		finish_phase();
	endtask

	task automatic test_line_rate_tail();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int i = 0; i < 3; i++)
			send_frame(wellformed_hdr());
		finish_phase();
	endtask

	initial begin : result_stall_gen
		int left;
		left      = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				left     = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (left > 0) begin
				out_stall <= 1'b1;
				left--;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				left = $urandom_range(1, 17) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected result: category %0d key %h", category, key);
				fail_count++;
			end else begin
				want = verdict_q.pop_front();
				if (category !== want.cat) begin
					$error("category: expected %0d, got %0d", want.cat, category);
					fail_count++;
				end
				if (new_connection !== want.conn) begin
					$error("new_connection: expected %0d, got %0d", want.conn, new_connection);
					fail_count++;
				end
				if (key !== want.key) begin
					$error("key: expected %h, got %h", want.key, key);
					fail_count++;
				end
				cat_seen[want.cat]++;
				syn_seen += 32'(want.conn);
				results_checked++;
			end
		end
	end

	always @(negedge clk) begin : watchdog
		int unsigned idle_cycles;
		if (in_valid && in_stall)
			in_held++;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		frame_byte = 8'h00;
		last_byte  = 1'b0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_req   = 1'b0;
		clear_frame_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic();
		test_back_pressure();
		test_line_rate_tail();
		$display("Sent %0d frames in %0d beats; checked %0d results", frames_sent,
		         beats_sent, results_checked);
		$display("Categories eth/ip/udp/tcp: %0d/%0d/%0d/%0d, SYN %0d, input held %0d cycles",
		         cat_seen[0], cat_seen[1], cat_seen[2], cat_seen[3], syn_seen, in_held);
		if (fail_count == 0 && verdict_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
